/* src/ped_pkg.sv */
// package for the percent escape decoder: decode modes, result word type,
// character constants and the hex digit lookup; no dependencies
`default_nettype none

package ped_pkg;

  typedef enum logic [1:0] {
    ModePlain   = 2'd0,
    ModePercent = 2'd1,
    ModeDigit   = 2'd2
  } ped_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } ped_word_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } ped_hex_t;

  localparam logic [7:0] PercentChar  = 8'h25;
  localparam logic [7:0] QuestionChar = 8'h3F;
  localparam int unsigned QueueDepth  = 3;
  localparam int unsigned CountWidth  = $clog2(QueueDepth + 1);

  function automatic ped_hex_t hex_value(input logic [7:0] c);
    ped_hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r.val = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.val = 4'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/percent_escape_decoder_unit.sv */
// percent escape decoder top level: decode logic and a three-word result queue
// depends on ped_pkg
//
// result words of an accepted byte pass through the registered queue to the output
// throughput: one byte per cycle while at most one word is queued; a byte that yields
//   two words can pull ready low even when the output side drains one word per cycle
// reset: asynchronous active low; clears the decode mode, the held digit and the queue
`default_nettype none

module percent_escape_decoder_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] out_byte_o,
  output      logic       out_has_byte_o,
  output      logic       out_last_o
);
  import ped_pkg::*;

  ped_mode_e             mode_q, mode_d;
  logic      [3:0]       nib_q, nib_d;
  ped_word_t             q_q [QueueDepth];
  ped_word_t             q_d [QueueDepth];
  logic [CountWidth-1:0] cnt_q, cnt_d, base;
  ped_word_t             r0, r1;
  logic      [1:0]       n_res;
  ped_hex_t              hex;
  logic                  push, pop;

  assign hex        = hex_value(in_byte_i);
  assign in_ready_o = (cnt_q <= CountWidth'(1));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;

  // next state
  always_comb begin
    mode_d = mode_q;
    nib_d  = nib_q;
    case (mode_q)
      ModePercent: begin
        mode_d = ModePlain;
        if (!in_last_i) begin
          if (hex.ok) begin
            nib_d  = hex.val;
            mode_d = ModeDigit;
          end else if (in_byte_i == PercentChar) begin
            mode_d = ModePercent;
          end
        end
      end
      ModeDigit: begin
        mode_d = ModePlain;
        nib_d  = 4'd0;
      end
      default: begin
        mode_d = ModePlain;
        if (in_byte_i == PercentChar && !in_last_i) begin
          mode_d = ModePercent;
        end
      end
    endcase
    if (in_last_i) begin
      mode_d = ModePlain;
      nib_d  = 4'd0;
    end
  end

  // result words
  always_comb begin
    r0    = '{data: 8'd0, has_byte: 1'b0, last: 1'b1};
    r1    = '{data: in_byte_i, has_byte: 1'b1, last: 1'b0};
    n_res = 2'd0;
    case (mode_q)
      ModePercent: begin
        if (in_last_i) begin
          n_res = 2'd1;
        end else if (!hex.ok) begin
          r0    = '{data: PercentChar, has_byte: 1'b1, last: 1'b0};
          n_res = (in_byte_i == PercentChar) ? 2'd1 : 2'd2;
        end
      end
      ModeDigit: begin
        r0.data     = hex.ok ? {nib_q, hex.val} : QuestionChar;
        r0.has_byte = 1'b1;
        r0.last     = in_last_i;
        n_res       = 2'd1;
      end
      default: begin
        if (in_byte_i != PercentChar) begin
          r0    = '{data: in_byte_i, has_byte: 1'b1, last: in_last_i};
          n_res = 2'd1;
        end else if (in_last_i) begin
          n_res = 2'd1;
        end
      end
    endcase
  end

  // result queue
  always_comb begin
    base  = cnt_q - CountWidth'(pop);
    cnt_d = base;
    for (int i = 0; i < QueueDepth; i++) begin
      q_d[i] = q_q[i];
      if (pop && i < QueueDepth - 1) begin
        q_d[i] = q_q[i+1];
      end
      if (push && n_res != 2'd0 && base == CountWidth'(i)) begin
        q_d[i] = r0;
      end
      if (push && n_res == 2'd2 && base + CountWidth'(1) == CountWidth'(i)) begin
        q_d[i] = r1;
      end
    end
    if (push) begin
      cnt_d = base + CountWidth'(n_res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      nib_q  <= 4'd0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        mode_q <= mode_d;
        nib_q  <= nib_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign out_byte_o     = q_q[0].data;
  assign out_has_byte_o = q_q[0].has_byte;
  assign out_last_o     = q_q[0].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountWidth'(QueueDepth))
    else $error("result queue overfilled");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && in_last_i) |=> (mode_q == ModePlain && nib_q == 4'd0))
    else $error("decode state not cleared after last byte");

  a_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_has_byte_o) |-> (out_last_o && out_byte_o == 8'd0))
    else $error("end-only word malformed");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - CountWidth'(1)))
    else $error("queue count wrong after pop");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q >= $past(cnt_q)))
    else $error("queue count shrank on push");

endmodule

`default_nettype wire
